// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the controller RTL; both sample on aclk and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("same-cycle implication failed");

// The property must hold in the cycle after the condition.
`define ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("next-cycle implication failed");

`endif

// File: hw/rtl/ipid_pkg.sv
// Shared constants, control word types and the microcode ROM of the PID controller.
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

    localparam int DW     = 32;
    localparam int FW     = 16;
    localparam int PW     = FW + 1;
    localparam int STEP_W = 5;
    localparam int AW     = 5;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_GAIN_K        = 3'd0;
    localparam reg_idx_t REG_WEIGHT_B      = 3'd1;
    localparam reg_idx_t REG_WEIGHT_C      = 3'd2;
    localparam reg_idx_t REG_INTEGRAL_GAIN = 3'd3;
    localparam reg_idx_t REG_DERIV_POLE    = 3'd4;
    localparam reg_idx_t REG_DERIV_GAIN    = 3'd5;
    localparam reg_idx_t REG_OUT_MAX       = 3'd6;
    localparam reg_idx_t REG_OUT_MIN       = 3'd7;

    typedef logic [2:0] op_t;
    localparam op_t OP_NOP = 3'd0;
    localparam op_t OP_SUB = 3'd1;
    localparam op_t OP_ADD = 3'd2;
    localparam op_t OP_MUL = 3'd3;
    localparam op_t OP_RND = 3'd4;
    localparam op_t OP_FIN = 3'd5;

    typedef logic [4:0] src_t;
    localparam src_t SRC_SP   = 5'd0;
    localparam src_t SRC_PV   = 5'd1;
    localparam src_t SRC_TV   = 5'd2;
    localparam src_t SRC_PSP  = 5'd3;
    localparam src_t SRC_PPV  = 5'd4;
    localparam src_t SRC_PC   = 5'd5;
    localparam src_t SRC_PD   = 5'd6;
    localparam src_t SRC_T0   = 5'd7;
    localparam src_t SRC_T1   = 5'd8;
    localparam src_t SRC_T2   = 5'd9;
    localparam src_t SRC_T3   = 5'd10;
    localparam src_t SRC_K    = 5'd11;
    localparam src_t SRC_B    = 5'd12;
    localparam src_t SRC_C    = 5'd13;
    localparam src_t SRC_KI   = 5'd14;
    localparam src_t SRC_POLE = 5'd15;
    localparam src_t SRC_KD   = 5'd16;

    typedef logic [1:0] dst_t;
    localparam dst_t DST_T0 = 2'd0;
    localparam dst_t DST_T1 = 2'd1;
    localparam dst_t DST_T2 = 2'd2;
    localparam dst_t DST_T3 = 2'd3;

    typedef struct packed {
        op_t  op;
        src_t sa;
        src_t sb;
        dst_t dst;
        logic zero_d;
        logic jt;
    } uword_t;

    typedef struct packed {
        uword_t w;
        logic   en;
    } dp_ctrl_t;

    localparam logic [STEP_W-1:0] TRK_STEP = 5'd23;

    function automatic uword_t uw(input op_t op, input src_t sa, input src_t sb,
                                  input dst_t dst, input logic zd, input logic jt);
        uword_t w;
        w.op     = op;
        w.sa     = sa;
        w.sb     = sb;
        w.dst    = dst;
        w.zero_d = zd;
        w.jt     = jt;
        return w;
    endfunction

    // Temporaries: T0 dsp, T1 dpv then the new derivative, T2 the running increment,
    // T3 the unclamped control value.
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        unique case (step)
            5'd0:  w = uw(OP_SUB, SRC_SP,   SRC_PSP, DST_T0, 1'b0, 1'b1);
            5'd1:  w = uw(OP_SUB, SRC_PV,   SRC_PPV, DST_T1, 1'b0, 1'b0);
            5'd2:  w = uw(OP_MUL, SRC_B,    SRC_T0,  DST_T0, 1'b0, 1'b0);
            5'd3:  w = uw(OP_RND, SRC_T0,   SRC_T0,  DST_T2, 1'b0, 1'b0);
            5'd4:  w = uw(OP_SUB, SRC_T2,   SRC_T1,  DST_T2, 1'b0, 1'b0);
            5'd5:  w = uw(OP_MUL, SRC_K,    SRC_T2,  DST_T0, 1'b0, 1'b0);
            5'd6:  w = uw(OP_RND, SRC_T0,   SRC_T0,  DST_T2, 1'b0, 1'b0);
            5'd7:  w = uw(OP_MUL, SRC_C,    SRC_T0,  DST_T0, 1'b0, 1'b0);
            5'd8:  w = uw(OP_RND, SRC_T0,   SRC_T0,  DST_T0, 1'b0, 1'b0);
            5'd9:  w = uw(OP_SUB, SRC_T0,   SRC_T1,  DST_T0, 1'b0, 1'b0);
            5'd10: w = uw(OP_MUL, SRC_KD,   SRC_T0,  DST_T0, 1'b0, 1'b0);
            5'd11: w = uw(OP_RND, SRC_T0,   SRC_T0,  DST_T0, 1'b0, 1'b0);
            5'd12: w = uw(OP_MUL, SRC_POLE, SRC_PD,  DST_T0, 1'b0, 1'b0);
            5'd13: w = uw(OP_RND, SRC_T0,   SRC_T0,  DST_T1, 1'b0, 1'b0);
            5'd14: w = uw(OP_ADD, SRC_T1,   SRC_T0,  DST_T1, 1'b0, 1'b0);
            5'd15: w = uw(OP_SUB, SRC_SP,   SRC_PV,  DST_T0, 1'b0, 1'b0);
            5'd16: w = uw(OP_MUL, SRC_KI,   SRC_T0,  DST_T0, 1'b0, 1'b0);
            5'd17: w = uw(OP_RND, SRC_T0,   SRC_T0,  DST_T0, 1'b0, 1'b0);
            5'd18: w = uw(OP_ADD, SRC_T2,   SRC_T0,  DST_T2, 1'b0, 1'b0);
            5'd19: w = uw(OP_SUB, SRC_T1,   SRC_PD,  DST_T0, 1'b0, 1'b0);
            5'd20: w = uw(OP_ADD, SRC_T2,   SRC_T0,  DST_T2, 1'b0, 1'b0);
            5'd21: w = uw(OP_ADD, SRC_PC,   SRC_T2,  DST_T3, 1'b0, 1'b0);
            5'd22: w = uw(OP_FIN, SRC_T3,   SRC_T3,  DST_T0, 1'b0, 1'b0);
            5'd23: w = uw(OP_FIN, SRC_TV,   SRC_TV,  DST_T0, 1'b1, 1'b0);
            default: w = uw(OP_NOP, SRC_T0, SRC_T0,  DST_T0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/incremental_pid_with_tracking.sv
// Top level of the incremental PID controller: register port, sequencer and handshakes.
//
//   channel   direction  ports                                        transfer when
//   s_        in         setpoint, measured, track_enable, track_value s_valid && s_ready
//   m_        out        control_out                                  m_valid && m_ready
//   apb       in/out     psel penable pwrite paddr pwdata prdata      psel && penable
//
// A sample in normal mode runs its microcode steps in order on the single shared
// multiplier and saturating adder. A tracking sample jumps from the first step straight
// to the tracking step. The input is taken again the cycle after the result is loaded.
// Reset clears the configuration to its defaults and the controller history to zero.
// A result that waits on m_ready stalls only the final step of the next sample.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module incremental_pid_with_tracking (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ipid_pkg::AW-1:0]        paddr,
    input  wire logic [ipid_pkg::DW-1:0]        pwdata,
    output logic [ipid_pkg::DW-1:0]             prdata,
    output logic                                pready,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [ipid_pkg::DW-1:0] s_setpoint,
    input  wire logic signed [ipid_pkg::DW-1:0] s_measured,
    input  wire logic                           s_track_enable,
    input  wire logic signed [ipid_pkg::DW-1:0] s_track_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [ipid_pkg::DW-1:0]      m_control_out
);

    localparam int DW     = ipid_pkg::DW;
    localparam int PW     = ipid_pkg::PW;
    localparam int STEP_W = ipid_pkg::STEP_W;

    logic signed [DW-1:0] gain_k_reg, weight_b_reg, weight_c_reg, integral_gain_reg;
    logic signed [DW-1:0] deriv_gain_reg, out_max_reg, out_min_reg;
    logic [PW-1:0]        deriv_pole_reg;

    logic signed [DW-1:0] sp_reg, pv_reg, tv_reg;
    logic                 trk_reg;

    logic                 busy_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 m_valid_reg;
    logic signed [DW-1:0] out_reg;

    ipid_pkg::uword_t     uword;
    ipid_pkg::dp_ctrl_t   dp_ctrl;
    ipid_pkg::reg_idx_t   reg_idx;
    logic                 cfg_write;
    logic                 accept;
    logic                 is_fin;
    logic                 step_en;
    logic                 out_load;
    logic signed [DW-1:0] cs_value;

    assign reg_idx   = paddr[ipid_pkg::AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_k_reg        <= DW'(1) << ipid_pkg::FW;
            weight_b_reg      <= DW'(1) << ipid_pkg::FW;
            weight_c_reg      <= '0;
            integral_gain_reg <= '0;
            deriv_pole_reg    <= '0;
            deriv_gain_reg    <= '0;
            out_max_reg       <= {1'b0, {(DW-1){1'b1}}};
            out_min_reg       <= {1'b1, {(DW-1){1'b0}}};
        end else if (cfg_write) begin
            unique case (reg_idx)
                ipid_pkg::REG_GAIN_K:        gain_k_reg        <= pwdata;
                ipid_pkg::REG_WEIGHT_B:      weight_b_reg      <= pwdata;
                ipid_pkg::REG_WEIGHT_C:      weight_c_reg      <= pwdata;
                ipid_pkg::REG_INTEGRAL_GAIN: integral_gain_reg <= pwdata;
                ipid_pkg::REG_DERIV_POLE:    deriv_pole_reg    <= pwdata[PW-1:0];
                ipid_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= pwdata;
                ipid_pkg::REG_OUT_MAX:       out_max_reg       <= pwdata;
                ipid_pkg::REG_OUT_MIN:       out_min_reg       <= pwdata;
                default:                     gain_k_reg        <= gain_k_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ipid_pkg::REG_GAIN_K:        prdata = gain_k_reg;
            ipid_pkg::REG_WEIGHT_B:      prdata = weight_b_reg;
            ipid_pkg::REG_WEIGHT_C:      prdata = weight_c_reg;
            ipid_pkg::REG_INTEGRAL_GAIN: prdata = integral_gain_reg;
            ipid_pkg::REG_DERIV_POLE:    prdata = DW'(deriv_pole_reg);
            ipid_pkg::REG_DERIV_GAIN:    prdata = deriv_gain_reg;
            ipid_pkg::REG_OUT_MAX:       prdata = out_max_reg;
            ipid_pkg::REG_OUT_MIN:       prdata = out_min_reg;
            default:                     prdata = '0;
        endcase
    end

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            sp_reg  <= s_setpoint;
            pv_reg  <= s_measured;
            tv_reg  <= s_track_value;
            trk_reg <= s_track_enable;
        end
    end

    // The final step waits while the previous result has not been taken.
    always_comb begin
        uword    = ipid_pkg::ucode(step_reg);
        is_fin   = (uword.op == ipid_pkg::OP_FIN);
        step_en  = busy_reg && !(is_fin && m_valid_reg && !m_ready);
        out_load = step_en && is_fin;
        dp_ctrl.w  = uword;
        dp_ctrl.en = step_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (step_en) begin
            if (is_fin) begin
                busy_reg <= 1'b0;
            end else if (uword.jt && trk_reg) begin
                step_reg <= ipid_pkg::TRK_STEP;
            end else begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    ipid_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (dp_ctrl),
        .sp            (sp_reg),
        .pv            (pv_reg),
        .tv            (tv_reg),
        .gain_k        (gain_k_reg),
        .weight_b      (weight_b_reg),
        .weight_c      (weight_c_reg),
        .integral_gain (integral_gain_reg),
        .deriv_pole    (deriv_pole_reg),
        .deriv_gain    (deriv_gain_reg),
        .out_max       (out_max_reg),
        .out_min       (out_min_reg),
        .cs_value      (cs_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= cs_value;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_control_out = out_reg;

    `ASSERT_NXT(a_accept_then_busy, accept, !s_ready)
    `ASSERT_IMP(a_no_result_overwrite, out_load, !m_valid_reg || m_ready)
    `ASSERT_NXT(a_track_takes_short_path, busy_reg && (step_reg == '0) && trk_reg,
        busy_reg && (step_reg == ipid_pkg::TRK_STEP))

endmodule

`default_nettype wire

// File: hw/rtl/ipid_fmul.sv
// Shared fixed-point multiplier: registered magnitude product, then rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module ipid_fmul (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic signed [ipid_pkg::DW:0]  opa,
    input  wire logic signed [ipid_pkg::DW:0]  opb,
    output logic signed [ipid_pkg::DW-1:0]     result
);

    localparam int DW = ipid_pkg::DW;
    localparam int FW = ipid_pkg::FW;
    localparam int QW = 2 * DW - FW;

    logic [DW:0]     abs_a;
    logic [DW:0]     abs_b;
    logic [2*DW-1:0] prod_reg;
    logic [2*DW-1:0] prod_next;
    logic            neg_reg;
    logic            neg_next;
    logic [2*DW-1:0] rounded;
    logic [QW-1:0]   quot;
    logic [QW-1:0]   lim;
    logic [QW-1:0]   qsat;
    logic [DW-1:0]   qlow;

    always_comb begin
        abs_a     = opa[DW] ? -opa : opa;
        abs_b     = opb[DW] ? -opb : opb;
        prod_next = (2*DW)'(abs_a[DW-1:0]) * (2*DW)'(abs_b[DW-1:0]);
        neg_next  = opa[DW] ^ opb[DW];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
    end

    // Halves round away from zero because the rounding acts on the magnitude.
    always_comb begin
        rounded = prod_reg + ((2*DW)'(1) << (FW - 1));
        quot    = rounded[2*DW-1:FW];
        lim     = neg_reg ? (QW'(1) << (DW - 1)) : ((QW'(1) << (DW - 1)) - QW'(1));
        qsat    = (quot > lim) ? lim : quot;
        qlow    = qsat[DW-1:0];
        result  = neg_reg ? -$signed(qlow) : $signed(qlow);
    end

endmodule

`default_nettype wire

// File: hw/rtl/ipid_dpath.sv
// Datapath of the PID controller: operand selection, saturating adder, multiplier and state.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ipid_dpath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ipid_pkg::dp_ctrl_t             ctrl,
    input  wire logic signed [ipid_pkg::DW-1:0] sp,
    input  wire logic signed [ipid_pkg::DW-1:0] pv,
    input  wire logic signed [ipid_pkg::DW-1:0] tv,
    input  wire logic signed [ipid_pkg::DW-1:0] gain_k,
    input  wire logic signed [ipid_pkg::DW-1:0] weight_b,
    input  wire logic signed [ipid_pkg::DW-1:0] weight_c,
    input  wire logic signed [ipid_pkg::DW-1:0] integral_gain,
    input  wire logic        [ipid_pkg::PW-1:0] deriv_pole,
    input  wire logic signed [ipid_pkg::DW-1:0] deriv_gain,
    input  wire logic signed [ipid_pkg::DW-1:0] out_max,
    input  wire logic signed [ipid_pkg::DW-1:0] out_min,
    output logic signed [ipid_pkg::DW-1:0]      cs_value
);

    localparam int DW = ipid_pkg::DW;
    localparam int PW = ipid_pkg::PW;

    logic signed [DW-1:0] psp_reg, ppv_reg, pc_reg, pd_reg;
    logic signed [DW-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [DW:0]   opa, opb;
    logic signed [DW:0]   sum;
    logic signed [DW-1:0] alu_sat;
    logic signed [DW-1:0] rnd_val;
    logic signed [DW-1:0] wb_val;
    logic signed [DW-1:0] clamp_hi;
    logic                 wb_en;

    function automatic logic signed [DW:0] pick(
        input ipid_pkg::src_t       s,
        input logic signed [DW-1:0] v_sp, input logic signed [DW-1:0] v_pv,
        input logic signed [DW-1:0] v_tv, input logic signed [DW-1:0] v_psp,
        input logic signed [DW-1:0] v_ppv, input logic signed [DW-1:0] v_pc,
        input logic signed [DW-1:0] v_pd, input logic signed [DW-1:0] v_t0,
        input logic signed [DW-1:0] v_t1, input logic signed [DW-1:0] v_t2,
        input logic signed [DW-1:0] v_t3, input logic signed [DW-1:0] v_k,
        input logic signed [DW-1:0] v_b, input logic signed [DW-1:0] v_c,
        input logic signed [DW-1:0] v_ki, input logic [PW-1:0] v_pole,
        input logic signed [DW-1:0] v_kd);
        logic signed [DW-1:0] v;
        logic signed [DW:0]   r;
        v = '0;
        unique case (s)
            ipid_pkg::SRC_SP:   v = v_sp;
            ipid_pkg::SRC_PV:   v = v_pv;
            ipid_pkg::SRC_TV:   v = v_tv;
            ipid_pkg::SRC_PSP:  v = v_psp;
            ipid_pkg::SRC_PPV:  v = v_ppv;
            ipid_pkg::SRC_PC:   v = v_pc;
            ipid_pkg::SRC_PD:   v = v_pd;
            ipid_pkg::SRC_T0:   v = v_t0;
            ipid_pkg::SRC_T1:   v = v_t1;
            ipid_pkg::SRC_T2:   v = v_t2;
            ipid_pkg::SRC_T3:   v = v_t3;
            ipid_pkg::SRC_K:    v = v_k;
            ipid_pkg::SRC_B:    v = v_b;
            ipid_pkg::SRC_C:    v = v_c;
            ipid_pkg::SRC_KI:   v = v_ki;
            ipid_pkg::SRC_POLE: v = '0;
            ipid_pkg::SRC_KD:   v = v_kd;
            default:            v = '0;
        endcase
        // The pole is the one unsigned operand, so it is zero extended.
        if (s == ipid_pkg::SRC_POLE) begin
            r = $signed({{(DW + 1 - PW){1'b0}}, v_pole});
        end else begin
            r = {v[DW-1], v};
        end
        return r;
    endfunction

    always_comb begin
        opa = pick(ctrl.w.sa, sp, pv, tv, psp_reg, ppv_reg, pc_reg, pd_reg,
                   t0_reg, t1_reg, t2_reg, t3_reg, gain_k, weight_b, weight_c,
                   integral_gain, deriv_pole, deriv_gain);
        opb = pick(ctrl.w.sb, sp, pv, tv, psp_reg, ppv_reg, pc_reg, pd_reg,
                   t0_reg, t1_reg, t2_reg, t3_reg, gain_k, weight_b, weight_c,
                   integral_gain, deriv_pole, deriv_gain);
    end

    ipid_fmul u_fmul (
        .aclk   (aclk),
        .load   (ctrl.en && (ctrl.w.op == ipid_pkg::OP_MUL)),
        .opa    (opa),
        .opb    (opb),
        .result (rnd_val)
    );

    always_comb begin
        if (ctrl.w.op == ipid_pkg::OP_SUB) begin
            sum = {opa[DW-1], opa[DW-1:0]} - {opb[DW-1], opb[DW-1:0]};
        end else begin
            sum = {opa[DW-1], opa[DW-1:0]} + {opb[DW-1], opb[DW-1:0]};
        end
        if (sum[DW] != sum[DW-1]) begin
            alu_sat = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            alu_sat = sum[DW-1:0];
        end
    end

    // Upper limit first, then lower, so crossed limits leave the lower one.
    always_comb begin
        clamp_hi = ($signed(opa[DW-1:0]) > out_max) ? out_max : $signed(opa[DW-1:0]);
        cs_value = (clamp_hi < out_min) ? out_min : clamp_hi;
    end

    always_comb begin
        wb_en  = 1'b0;
        wb_val = alu_sat;
        case (ctrl.w.op) inside
            ipid_pkg::OP_SUB, ipid_pkg::OP_ADD: wb_en = ctrl.en;
            ipid_pkg::OP_RND: begin
                wb_en  = ctrl.en;
                wb_val = rnd_val;
            end
            default: wb_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wb_en) begin
            unique case (ctrl.w.dst)
                ipid_pkg::DST_T0: t0_reg <= wb_val;
                ipid_pkg::DST_T1: t1_reg <= wb_val;
                ipid_pkg::DST_T2: t2_reg <= wb_val;
                ipid_pkg::DST_T3: t3_reg <= wb_val;
                default:          t0_reg <= wb_val;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psp_reg <= '0;
            ppv_reg <= '0;
            pc_reg  <= '0;
            pd_reg  <= '0;
        end else if (ctrl.en && (ctrl.w.op == ipid_pkg::OP_FIN)) begin
            psp_reg <= sp;
            ppv_reg <= pv;
            pc_reg  <= cs_value;
            pd_reg  <= ctrl.w.zero_d ? '0 : t1_reg;
        end
    end

    `ASSERT_NXT(a_track_clears_deriv,
        ctrl.en && (ctrl.w.op == ipid_pkg::OP_FIN) && ctrl.w.zero_d, pd_reg == '0)

endmodule

`default_nettype wire

// File: tb/sv/tb_incremental_pid_with_tracking.sv
// Self-checking testbench of the incremental PID controller with tracking and output clamps.
`timescale 1ns / 1ps

module tb_incremental_pid_with_tracking;
    import ipid_pkg::*;

    typedef logic signed [DW-1:0] q_t;

    typedef struct {
        q_t   setpoint;
        q_t   measured;
        logic track_enable;
        q_t   track_value;
        bit   typed;
        q_t   control;
    } sample_row_t;

    typedef struct {
        q_t              gain_k;
        q_t              weight_b;
        q_t              weight_c;
        q_t              integral_gain;
        logic [DW-1:0]   deriv_pole;
        q_t              deriv_gain;
        q_t              out_max;
        q_t              out_min;
        int              send_idle;
        int              recv_stall;
        bit              pressure;
    } loop_setting_t;

    localparam longint QMAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint QMIN = -(longint'(1) <<< (DW - 1));
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_SAMPLES = 232;
    localparam int NUM_DIRECTED = 13;
    localparam int NUM_PHASES = 6;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [AW-1:0] paddr;
    logic [DW-1:0] pwdata;
    logic [DW-1:0] prdata;
    logic          pready;
    logic          s_valid;
    logic          s_ready;
    q_t            s_setpoint;
    q_t            s_measured;
    logic          s_track_enable;
    q_t            s_track_value;
    logic          m_valid;
    logic          m_ready;
    q_t            m_control_out;

    // Controller copy kept by the testbench: configuration and history.
    q_t            cfg_gain_k = q_t'(1 << FW);
    q_t            cfg_weight_b = q_t'(1 << FW);
    q_t            cfg_weight_c = '0;
    q_t            cfg_integral_gain = '0;
    logic [PW-1:0] cfg_deriv_pole = '0;
    q_t            cfg_deriv_gain = '0;
    q_t            cfg_out_max = q_t'(QMAX);
    q_t            cfg_out_min = q_t'(QMIN);
    q_t            hist_setpoint = '0;
    q_t            hist_measured = '0;
    q_t            hist_control = '0;
    q_t            hist_deriv = '0;

    q_t            control_q[$];
    q_t            want;
    bit            typed_pending = 1'b0;
    q_t            typed_control = '0;
    int            send_idle = 0;
    int            recv_stall = 0;
    int            hold_cycles = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    int            result_count = 0;

    incremental_pid_with_tracking uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_setpoint     (s_setpoint),
        .s_measured     (s_measured),
        .s_track_enable (s_track_enable),
        .s_track_value  (s_track_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_control_out  (m_control_out)
    );

    always #1 aclk = ~aclk;

    function automatic longint clip(input longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    // Exact product, rounded half away from zero to FW fraction bits, then saturated.
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        longint m;
        bit     neg;
        p = a * b;
        neg = (p < 0);
        m = neg ? -p : p;
        m = (m + (longint'(1) <<< (FW - 1))) >>> FW;
        if (neg) begin
            if (m > -QMIN) m = -QMIN;
            return -m;
        end
        if (m > QMAX) m = QMAX;
        return m;
    endfunction

    function automatic q_t next_control(input q_t sp, input q_t pv, input logic te,
                                        input q_t tv);
        longint dsp;
        longint dpv;
        longint dp;
        longint di;
        longint d;
        longint dd;
        longint cs;
        if (!te) begin
            dsp = clip(longint'(sp) - longint'(hist_setpoint));
            dpv = clip(longint'(pv) - longint'(hist_measured));
            dp = qmul(cfg_gain_k, clip(qmul(cfg_weight_b, dsp) - dpv));
            di = qmul(cfg_integral_gain, clip(longint'(sp) - longint'(pv)));
            d = clip(qmul(longint'(cfg_deriv_pole), longint'(hist_deriv)) +
                     qmul(cfg_deriv_gain, clip(qmul(cfg_weight_c, dsp) - dpv)));
            dd = clip(d - longint'(hist_deriv));
            cs = clip(longint'(hist_control) + clip(clip(dp + di) + dd));
        end else begin
            cs = tv;
            d = 0;
        end
        // The upper clamp is applied first, so crossed limits yield out_min.
        if (cs > longint'(cfg_out_max)) cs = cfg_out_max;
        if (cs < longint'(cfg_out_min)) cs = cfg_out_min;
        hist_setpoint = sp;
        hist_measured = pv;
        hist_control = q_t'(cs);
        hist_deriv = q_t'(d);
        return q_t'(cs);
    endfunction

    function automatic q_t rand_value();
        case ($urandom_range(9))
            0, 1: return q_t'($urandom);
            2: begin
                case ($urandom_range(4))
                    0: return q_t'(QMAX);
                    1: return q_t'(QMIN);
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return q_t'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input q_t got, input q_t exp_val);
        $display("%0d: %s: got %h, want %h", result_count, what, got, exp_val);
        mismatches++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DW-1:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_GAIN_K:        cfg_gain_k = val;
            REG_WEIGHT_B:      cfg_weight_b = val;
            REG_WEIGHT_C:      cfg_weight_c = val;
            REG_INTEGRAL_GAIN: cfg_integral_gain = val;
            REG_DERIV_POLE:    cfg_deriv_pole = val[PW-1:0];
            REG_DERIV_GAIN:    cfg_deriv_gain = val;
            REG_OUT_MAX:       cfg_out_max = val;
            REG_OUT_MIN:       cfg_out_min = val;
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(input loop_setting_t st);
        write_reg(REG_GAIN_K, st.gain_k);
        write_reg(REG_WEIGHT_B, st.weight_b);
        write_reg(REG_WEIGHT_C, st.weight_c);
        write_reg(REG_INTEGRAL_GAIN, st.integral_gain);
        write_reg(REG_DERIV_POLE, st.deriv_pole);
        write_reg(REG_DERIV_GAIN, st.deriv_gain);
        write_reg(REG_OUT_MAX, st.out_max);
        write_reg(REG_OUT_MIN, st.out_min);
        send_idle = st.send_idle;
        recv_stall = st.recv_stall;
    endtask

    // Offers one sample and returns at the edge where its transfer happens.
    task automatic drive_sample(input sample_row_t r);
        while ($urandom_range(99) < send_idle) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_setpoint <= r.setpoint;
        s_measured <= r.measured;
        s_track_enable <= r.track_enable;
        s_track_value <= r.track_value;
        typed_pending = r.typed;
        typed_control = r.control;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (control_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = next_control(s_setpoint, s_measured, s_track_enable, s_track_value);
                control_q.push_back(typed_pending ? typed_control : want);
            end
            if (m_valid && m_ready) begin
                result_count++;
                if (control_q.size() == 0) begin
                    report_mismatch("control_out with no sample pending", m_control_out, '0);
                end else begin
                    want = control_q.pop_front();
                    if (m_control_out !== want)
                        report_mismatch("control_out", m_control_out, want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     control_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        sample_row_t   steps [NUM_DIRECTED];
        loop_setting_t phases [NUM_PHASES];
        sample_row_t   r;
        q_t            gen_sp;
        q_t            gen_pv;
        q_t            lim_a;
        q_t            lim_b;

        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_setpoint = '0;
        s_measured = '0;
        s_track_enable = 1'b0;
        s_track_value = '0;
        m_ready = 1'b0;

        // Directed samples at reset: unit K and b, zero c, Ki and Kd, widest clamps.
        steps = '{
            '{32'sh0000_0000, 32'sh0000_0000, 1'b0, 32'sh0000_0000, 1'b1, 32'sh0000_0000},
            '{32'sh0001_0000, 32'sh0000_0000, 1'b0, 32'shFFFF_FFFF, 1'b1, 32'sh0001_0000},
            '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF},
            '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'sh8000_0000, 1'b1, 32'sh8000_0000},
            '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 32'sh5555_5555, 1'b0, 32'sh0000_0000},
            '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 32'shAAAA_AAAA, 1'b0, 32'sh0000_0000},
            '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 32'sh0000_0000, 1'b0, 32'sh0000_0000},
            '{32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'sh0000_0000, 1'b1, 32'sh0000_0000},
            '{32'sh0000_8000, 32'shFFFF_8000, 1'b0, 32'sh0000_0000, 1'b0, 32'sh0000_0000},
            '{32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, 32'sh0000_0001, 1'b0, 32'sh0000_0000},
            '{32'shFFFF_FFFF, 32'sh0000_0001, 1'b0, 32'shFFFF_FFFF, 1'b0, 32'sh0000_0000},
            '{32'sh7FFF_0000, 32'sh8001_0000, 1'b0, 32'sh7FFF_0000, 1'b0, 32'sh0000_0000},
            '{32'sh0000_0001, 32'sh0000_0001, 1'b1, 32'sh1234_5678, 1'b1, 32'sh1234_5678}
        };

        phases = '{
            // Moderate gains, symmetric clamps.
            '{32'sh0001_8000, 32'sh0000_C000, 32'sh0000_4000, 32'sh0000_0CCD, 32'h0000_8000,
              32'sh0002_0000, 32'sh0064_0000, -32'sh0064_0000, 0, 0, 1'b0},
            // Every register at an extreme, pole at exactly one.
            '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0001_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 81, 0, 1'b0},
            // Crossed clamps: out_min lies above out_max.
            '{32'sh0002_0000, 32'sh0001_0000, 32'sh0000_8000, 32'sh0000_2000, 32'h0000_4000,
              32'sh0001_0000, 32'shFFFB_0000, 32'sh0005_0000, 0, 81, 1'b0},
            // Pole above one, with the upper data bits set to show they are dropped.
            '{32'shFFFF_0000, 32'sh8000_0000, 32'shFFFE_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF,
              32'shFFFE_8000, 32'sh4000_0000, 32'shC000_0000, 6, 6, 1'b0},
            // All gains zero and equal clamps; the receiver holds off once for long.
            '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'h0000_0000,
              32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 0, 0, 1'b1},
            '{32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 32'h0000_0000,
              32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 1'b0}
        };

        // The last setting is drawn at random with a sane ordering of the clamps.
        phases[5].gain_k = q_t'($urandom_range(32'h0004_0000));
        phases[5].weight_b = q_t'($urandom_range(32'h0002_0000));
        phases[5].weight_c = q_t'($urandom_range(32'h0002_0000));
        phases[5].integral_gain = q_t'($urandom_range(32'h0000_4000));
        phases[5].deriv_pole = $urandom_range(32'h0001_0000);
        phases[5].deriv_gain = q_t'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        lim_a = rand_value();
        lim_b = rand_value();
        phases[5].out_max = (lim_a > lim_b) ? lim_a : lim_b;
        phases[5].out_min = (lim_a > lim_b) ? lim_b : lim_a;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            drive_sample(steps[i]);
        drain();

        gen_sp = '0;
        gen_pv = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_setting(phases[p]);
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                // Mostly a held setpoint with a slowly drifting measurement, so the
                // loop history matters; now and then a jump or an extreme value.
                if ($urandom_range(9) == 0)
                    gen_sp = rand_value();
                if ($urandom_range(99) < 15)
                    gen_pv = rand_value();
                else
                    gen_pv = q_t'(clip(longint'(gen_pv) +
                                       longint'($urandom_range(16'hFFFF)) - 32768));
                r.setpoint = gen_sp;
                r.measured = gen_pv;
                r.track_enable = ($urandom_range(99) < 8);
                r.track_value = $urandom_range(1) ? q_t'($urandom) : rand_value();
                r.typed = 1'b0;
                r.control = '0;
                if (phases[p].pressure && n == 30)
                    hold_cycles = 400;
                drive_sample(r);
            end
            drain();
        end

        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
